FILE: rtl/core/ftn_pkg.sv
// ----------------------------------------------------------------------------
// ftn_pkg
// Shared widths, constants, types and helper functions for the
// frequency to note converter.
// ----------------------------------------------------------------------------
package ftn_pkg;

   // field widths
   localparam int FREQ_W        = 24;
   localparam int LOG_FRAC_BITS = 16;
   localparam int MANT_W        = 32;
   localparam int POS_W         = 5;
   localparam int PC_W          = 4;
   localparam int OCT_W         = 5;
   localparam int CENTS_W       = 15;
   localparam int MIDI_W        = 9;
   localparam int NOTE_W        = 9;
   localparam int QUO_W         = 5;

   // semitone value n is signed with LOG_FRAC_BITS fraction bits
   localparam int N_W           = LOG_FRAC_BITS + 11;

   // reference pitch after reset, 440 Hz in Q16.8
   localparam logic [FREQ_W-1:0] REF_RESET = FREQ_W'(112640);

   // note arithmetic constants
   localparam int A4_OFFSET     = 57;
   localparam int NOTE_LIMIT    = 192;
   localparam int SEMITONES     = 12;
   localparam int OCT_BIAS      = 16;
   localparam int DIV12_MUL     = 342;
   localparam int DIV12_SHIFT   = 12;
   localparam int DIV12_PROD_W  = NOTE_W + 9;
   localparam int CENTS_SCALE   = 25600;
   localparam int CENTS_PROD_W  = LOG_FRAC_BITS + CENTS_W;

   // normalized operand: leading-one position and Q1.31 mantissa
   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [MANT_W-1:0] mant;
   } norm_type;

   // result of one squaring step
   typedef struct packed {
      logic              frac_bit;
      logic [MANT_W-1:0] mant;
   } step_type;

   // payload of the log2 pipeline, frequency and reference lanes side by side
   typedef struct packed {
      logic                     zero;
      logic [POS_W-1:0]         pos_f;
      logic [POS_W-1:0]         pos_r;
      logic [MANT_W-1:0]        mant_f;
      logic [MANT_W-1:0]        mant_r;
      logic [LOG_FRAC_BITS-1:0] frac_f;
      logic [LOG_FRAC_BITS-1:0] frac_r;
   } log_type;

   // leading-one detect and shift to a Q1.31 mantissa
   function automatic norm_type normalize(input logic [FREQ_W-1:0] x);
      norm_type         res;
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 1; i < FREQ_W; i++) begin
         if (x[i]) begin
            p = POS_W'(i);
         end
      end
      res.pos  = p;
      res.mant = MANT_W'(x) << (POS_W'(MANT_W - 1) - p);
      return res;
   endfunction

   // square the mantissa, emit one fraction bit and renormalize
   function automatic step_type square_step(input logic [MANT_W-1:0] m);
      step_type            res;
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     t;
      sq = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
      t  = sq[2*MANT_W-1:MANT_W-1];
      res.frac_bit = t[MANT_W];
      if (t[MANT_W]) begin
         res.mant = t[MANT_W:1];
      end else begin
         res.mant = t[MANT_W-1:0];
      end
      return res;
   endfunction

   // midi number from octave and pitch class
   function automatic logic [MIDI_W-1:0] midi_of(input logic [OCT_W-1:0] oct,
                                                  input logic [PC_W-1:0] pc);
      logic [MIDI_W-1:0] oct_x;
      oct_x = {{(MIDI_W-OCT_W){oct[OCT_W-1]}}, oct} + MIDI_W'(1);
      return MIDI_W'(oct_x * MIDI_W'(SEMITONES)) + MIDI_W'(pc);
   endfunction

endpackage

FILE: rtl/core/ftn_req_if.sv
// ----------------------------------------------------------------------------
// ftn_req_if
// Request channel: one frequency in unsigned Q16.8 Hz.
// ----------------------------------------------------------------------------
interface ftn_req_if import ftn_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] frequency;

   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);

endinterface

FILE: rtl/core/ftn_rsp_if.sv
// ----------------------------------------------------------------------------
// ftn_rsp_if
// Response channel: note, octave, cents, midi number and invalid flag.
// ----------------------------------------------------------------------------
interface ftn_rsp_if import ftn_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [PC_W-1:0]    semitone;
   logic [OCT_W-1:0]   octave;
   logic [CENTS_W-1:0] cents;
   logic [MIDI_W-1:0]  midi_note;
   logic               invalid;

   modport source (output valid, output semitone, output octave, output cents,
                   output midi_note, output invalid, input ready);
   modport sink   (input valid, input semitone, input octave, input cents,
                   input midi_note, input invalid, output ready);

endinterface

FILE: rtl/core/frequency_to_note.sv
// ----------------------------------------------------------------------------
// frequency_to_note
// Converts a frequency in Q16.8 Hz into pitch class, octave, cents and midi
// number relative to a programmable A4 reference.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    frequency (24b, Q16.8 Hz)
//   rsp_chan   out   valid/ready    semitone, octave, cents, midi_note, invalid
//   csr        in    write enable   reference_pitch (24b, Q16.8 Hz)
//
// One request per cycle while the response channel is not stalled; each request
// passes through 20 register stages: one normalize stage, 16 squaring stages
// (one fraction bit each, set by LOG_FRAC_BITS) and three note stages.
// Reset empties the pipeline and sets the reference to 440 Hz.
// Each stage holds its content while the next is full, so a stalled
// response backs up stage by stage and empty stages keep taking requests.
// ----------------------------------------------------------------------------
module frequency_to_note import ftn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ftn_req_if.sink           req_chan,
   ftn_rsp_if.source         rsp_chan,
   input  logic              csr_write_enable,
   input  logic [FREQ_W-1:0] csr_write_data
);

   logic [FREQ_W-1:0] reference_pitch_ff, reference_pitch_in;

   logic              ent_valid_ff, ent_valid_in, ent_ready;
   log_type           ent_data_ff, ent_data_in;
   logic [FREQ_W-1:0] ref_safe;
   norm_type          norm_f, norm_r;

   logic [LOG_FRAC_BITS:0] lv, lr;
   log_type                ld [LOG_FRAC_BITS+1];

   // reference pitch register
   assign reference_pitch_in = csr_write_enable ? csr_write_data : reference_pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_pitch_ff <= REF_RESET;
      end else begin
         reference_pitch_ff <= reference_pitch_in;
      end
   end

   // entry stage: leading-one detect and normalize both operands
   assign ent_ready      = !ent_valid_ff || lr[0];
   assign req_chan.ready = ent_ready;
   assign ent_valid_in   = ent_ready ? req_chan.valid : ent_valid_ff;

   always_comb begin
      ref_safe = (reference_pitch_ff == '0) ? FREQ_W'(1) : reference_pitch_ff;
      norm_f   = normalize(req_chan.frequency);
      norm_r   = normalize(ref_safe);
      ent_data_in.zero   = (req_chan.frequency == '0);
      ent_data_in.pos_f  = norm_f.pos;
      ent_data_in.pos_r  = norm_r.pos;
      ent_data_in.mant_f = norm_f.mant;
      ent_data_in.mant_r = norm_r.mant;
      ent_data_in.frac_f = '0;
      ent_data_in.frac_r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_ready && req_chan.valid) begin
         ent_data_ff <= ent_data_in;
      end
   end

   assign lv[0] = ent_valid_ff;
   assign ld[0] = ent_data_ff;

   // squaring stages, one fraction bit each
   for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_sqr
      ftn_sqr_stage u_sqr (
         .clock    (clock),
         .reset    (reset),
         .up_valid (lv[k]),
         .up_ready (lr[k]),
         .up_data  (ld[k]),
         .dn_valid (lv[k+1]),
         .dn_ready (lr[k+1]),
         .dn_data  (ld[k+1])
      );
   end

   // note back end and response register
   ftn_note u_note (
      .clock    (clock),
      .reset    (reset),
      .up_valid (lv[LOG_FRAC_BITS]),
      .up_ready (lr[LOG_FRAC_BITS]),
      .up_data  (ld[LOG_FRAC_BITS]),
      .rsp      (rsp_chan)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.invalid |->
         rsp_chan.semitone == '0 && rsp_chan.octave == '0 &&
         rsp_chan.cents == '0 && rsp_chan.midi_note == '0)
      else $error("invalid response carries nonzero fields");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.invalid |->
         rsp_chan.semitone <= PC_W'(SEMITONES - 1))
      else $error("pitch class out of range");

   a_midi_match: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.invalid |->
         rsp_chan.midi_note == midi_of(rsp_chan.octave, rsp_chan.semitone))
      else $error("midi number disagrees with octave and pitch class");
`endif

endmodule

FILE: rtl/core/ftn_sqr_stage.sv
// ----------------------------------------------------------------------------
// ftn_sqr_stage
// One register stage of the log2 pipeline: squares both mantissas and
// shifts one more fraction bit into each log value.
// ----------------------------------------------------------------------------
module ftn_sqr_stage import ftn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  log_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output log_type dn_data
);

   logic     valid_ff, valid_in;
   log_type  data_ff, data_in;
   step_type step_f, step_r;

   // stage takes a new request when empty or when its content moves on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // squaring of both lanes
   always_comb begin
      step_f = square_step(up_data.mant_f);
      step_r = square_step(up_data.mant_r);
      data_in        = up_data;
      data_in.mant_f = step_f.mant;
      data_in.mant_r = step_r.mant;
      data_in.frac_f = {up_data.frac_f[LOG_FRAC_BITS-2:0], step_f.frac_bit};
      data_in.frac_r = {up_data.frac_r[LOG_FRAC_BITS-2:0], step_r.frac_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/core/ftn_note.sv
// ----------------------------------------------------------------------------
// ftn_note
// Back end: forms n = 12*(log2 f - log2 ref) + 57, saturates it, splits it
// into note and fraction, then octave, pitch class, midi number and cents.
// Three register stages, the last one is the response register.
// ----------------------------------------------------------------------------
module ftn_note import ftn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  log_type up_data,
   ftn_rsp_if.source rsp
);

   localparam logic [N_W-1:0] A4_FIX = N_W'(longint'(A4_OFFSET) << LOG_FRAC_BITS);
   localparam logic signed [N_W-1:0] N_HI =
      N_W'((longint'(NOTE_LIMIT) << LOG_FRAC_BITS) - 1);
   localparam logic signed [N_W-1:0] N_LO =
      N_W'(-(longint'(NOTE_LIMIT) << LOG_FRAC_BITS));

   // stage valid bits and ready chain
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic r1, r2, r3;

   // stage 1 signals
   logic [N_W-1:0]        a_f, a_r, d, n_raw;
   logic signed [N_W-1:0] n_sat;
   logic signed [N_W-1:0] n1_ff;
   logic                  zero1_ff;

   // stage 2 signals
   logic [NOTE_W-1:0]         note, u;
   logic [LOG_FRAC_BITS-1:0]  frac;
   logic [DIV12_PROD_W-1:0]   q_prod;
   logic [CENTS_PROD_W-1:0]   cents_prod;
   logic [NOTE_W-1:0]         note2_ff, u2_ff;
   logic [QUO_W-1:0]          q2_ff;
   logic [CENTS_W-1:0]        cents2_ff;
   logic                      zero2_ff;

   // stage 3 signals
   logic [NOTE_W-1:0]  q_x12, pc_wide;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [OCT_W-1:0]   oct_ff, oct_in;
   logic [CENTS_W-1:0] cents_ff, cents_in;
   logic [MIDI_W-1:0]  midi_ff, midi_in;
   logic               inv_ff;

   // ready chain
   assign r3       = !v3_ff || rsp.ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign up_ready = r1;
   assign v1_in    = r1 ? up_valid : v1_ff;
   assign v2_in    = r2 ? v1_ff : v2_ff;
   assign v3_in    = r3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: difference of logs times twelve plus offset, saturated
   always_comb begin
      a_f   = N_W'({up_data.pos_f, up_data.frac_f});
      a_r   = N_W'({up_data.pos_r, up_data.frac_r});
      d     = a_f - a_r;
      n_raw = (d << 3) + (d << 2) + A4_FIX;
      if ($signed(n_raw) < N_LO) begin
         n_sat = N_LO;
      end else if ($signed(n_raw) > N_HI) begin
         n_sat = N_HI;
      end else begin
         n_sat = $signed(n_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && up_valid) begin
         n1_ff    <= n_sat;
         zero1_ff <= up_data.zero;
      end
   end

   // stage 2: floor split, divide by twelve through reciprocal, cents scaling
   always_comb begin
      note       = n1_ff[LOG_FRAC_BITS +: NOTE_W];
      frac       = n1_ff[LOG_FRAC_BITS-1:0];
      u          = note + NOTE_W'(NOTE_LIMIT);
      q_prod     = DIV12_PROD_W'(u) * DIV12_PROD_W'(DIV12_MUL);
      cents_prod = CENTS_PROD_W'(frac) * CENTS_PROD_W'(CENTS_SCALE);
   end

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         note2_ff  <= note;
         u2_ff     <= u;
         q2_ff     <= q_prod[DIV12_SHIFT +: QUO_W];
         cents2_ff <= cents_prod[LOG_FRAC_BITS +: CENTS_W];
         zero2_ff  <= zero1_ff;
      end
   end

   // stage 3: pitch class, octave and midi number, zeroed on invalid input
   always_comb begin
      q_x12   = (NOTE_W'(q2_ff) << 3) + (NOTE_W'(q2_ff) << 2);
      pc_wide = u2_ff - q_x12;
      if (zero2_ff) begin
         pc_in    = '0;
         oct_in   = '0;
         cents_in = '0;
         midi_in  = '0;
      end else begin
         pc_in    = pc_wide[PC_W-1:0];
         oct_in   = OCT_W'(q2_ff - QUO_W'(OCT_BIAS));
         cents_in = cents2_ff;
         midi_in  = MIDI_W'(note2_ff + NOTE_W'(SEMITONES));
      end
   end

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         pc_ff    <= pc_in;
         oct_ff   <= oct_in;
         cents_ff <= cents_in;
         midi_ff  <= midi_in;
         inv_ff   <= zero2_ff;
      end
   end

   assign rsp.valid     = v3_ff;
   assign rsp.semitone  = pc_ff;
   assign rsp.octave    = oct_ff;
   assign rsp.cents     = cents_ff;
   assign rsp.midi_note = midi_ff;
   assign rsp.invalid   = inv_ff;

endmodule
